/* rtl/assert_macros.svh */
// Assertion macros shared by the queue and back end RTL modules of the outer band score block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, held off while reset is high.
`define OBML_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define OBML_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/obml_pkg.sv */
// Package with the types, constants and log table of the outer band score block.
`timescale 1ns / 1ps
`default_nettype none

package obml_pkg;

   // Stream limits and table size.
   localparam int MAX_SCORES     = 1048576;
   localparam int TBL_BITS       = 8;
   localparam int TBL_SIZE       = (1 << TBL_BITS) + 1;
   localparam int RBITS          = 32 - TBL_BITS;
   localparam int ROM_W          = 25;
   localparam int Q_DEPTH        = 4;

   // Datapath widths.
   localparam int SCORE_W        = 64;
   localparam int MEAN_W         = 32;
   localparam int USED_W         = 21;
   localparam int COUNT_W        = $clog2(MAX_SCORES + 1);
   localparam int LG_W           = 30;
   localparam int SUM_W          = LG_W + COUNT_W;
   localparam int MAG_W          = 30;
   localparam int LOG10_W        = 31;
   localparam int PRODC_W        = MAG_W + LOG10_W;

   // Fixed point constants.
   localparam logic [SCORE_W-2:0] CLAMP_MIN = 63'd4295;
   localparam logic [LOG10_W-1:0] LOG10_OF_2_Q32 = 31'd1292913987;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_UPPER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOWER = 1'd1;

   // Result status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FALLBACK = 2'd1;
   localparam logic [1:0] ST_BAD      = 2'd2;
   localparam logic [1:0] ST_OVF      = 2'd3;

   // One classified score as it waits between front and back.
   typedef struct packed {
      logic [SCORE_W-2:0] score;
      logic               sel;
      logic               last;
      logic               bad;
   } q_entry_type;

   // Queue fill status seen by front and back.
   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef logic [TBL_SIZE-1:0][ROM_W-1:0] rom_type;

   // Builds log2(1 + i/2^TBL_BITS) truncated to 24 fraction bits, in Q1.24, by repeated squaring.
   function automatic rom_type build_log_rom();
      rom_type           rom;
      logic [63:0]       m;
      logic [ROM_W-1:0]  r;
      for (int i = 0; i < TBL_SIZE - 1; i++) begin
         m = 64'(1 << 30) + (64'(i) << (30 - TBL_BITS));
         r = '0;
         for (int k = 1; k <= 24; k++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
               m = m >> 1;
               r = r | (ROM_W'(1) << (24 - k));
            end
         end
         rom[i] = r;
      end
      rom[TBL_SIZE-1] = ROM_W'(1) << 24;
      return rom;
   endfunction

   localparam rom_type LOG_ROM = build_log_rom();

endpackage

`default_nettype wire

/* rtl/obml_front.sv */
// Front end: configuration registers, score clamping and band classification.
`timescale 1ns / 1ps
`default_nettype none

module obml_front import obml_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic signed [SCORE_W-1:0] req_score,
   input  wire logic                   req_last_score,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [SCORE_W-1:0]     csr_data,
   input  wire q_status_type           q_status,
   output logic                        q_push,
   output q_entry_type                 q_wr_entry
);

   logic signed [SCORE_W-1:0] upper_ff, upper_in;
   logic signed [SCORE_W-1:0] lower_ff, lower_in;
   logic signed [SCORE_W-1:0] clamped;

   // Register writes.
   always_comb begin
      upper_in = upper_ff;
      lower_in = lower_ff;
      if (csr_we) begin
         case (csr_index)
            REG_UPPER: upper_in = csr_data;
            REG_LOWER: lower_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= '0;
         lower_ff <= '0;
      end else begin
         upper_ff <= upper_in;
         lower_ff <= lower_in;
      end
   end

   // A transaction is taken whenever the queue has room.
   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

   // Scores at or below zero are raised to CLAMP_MIN, a small positive score.
   assign clamped = (req_score <= 0) ? $signed({1'b0, CLAMP_MIN}) : req_score;

   // Classify against the band and mark a bad band (upper below lower) on every score.
   always_comb begin
      q_wr_entry.score = clamped[SCORE_W-2:0];
      q_wr_entry.sel   = (clamped >= upper_ff) || (clamped <= lower_ff);
      q_wr_entry.last  = req_last_score;
      q_wr_entry.bad   = upper_ff < lower_ff;
   end

endmodule

`default_nettype wire

/* rtl/obml_queue.sv */
// Short queue of classified scores between front and back.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module obml_queue import obml_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire q_entry_type wr_entry,
   input  wire logic        pop,
   output q_entry_type      rd_entry,
   output q_status_type     status
);

   localparam int PTR_W = $clog2(Q_DEPTH);
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   q_entry_type        slots_ff [Q_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(Q_DEPTH));
   assign rd_entry     = slots_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   `OBML_ASSERT(a_no_push_full, clock, reset, push |-> !status.full, "push into full queue")
   `OBML_ASSERT(a_no_pop_empty, clock, reset, pop |-> !status.empty, "pop from empty queue")
   `OBML_ASSERT(a_fill_bound, clock, reset, (status.full |=> (count_ff != '0)), "queue lost entries")

endmodule

`default_nettype wire

/* rtl/obml_back.sv */
// Back end: log10 sequencer, stream accumulators, mean divider and result register.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module obml_back import obml_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire q_status_type       q_status,
   input  wire q_entry_type        q_rd_entry,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [MEAN_W-1:0] rsp_mean_log,
   output logic [1:0]              rsp_status,
   output logic [USED_W-1:0]       rsp_used_count
);

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
   localparam logic [STATE_W-1:0] S_NORM   = 4'd1;
   localparam logic [STATE_W-1:0] S_LOOK   = 4'd2;
   localparam logic [STATE_W-1:0] S_MULF   = 4'd3;
   localparam logic [STATE_W-1:0] S_L2     = 4'd4;
   localparam logic [STATE_W-1:0] S_MULC   = 4'd5;
   localparam logic [STATE_W-1:0] S_ACC    = 4'd6;
   localparam logic [STATE_W-1:0] S_DIVSET = 4'd7;
   localparam logic [STATE_W-1:0] S_DIV    = 4'd8;
   localparam logic [STATE_W-1:0] S_DONE   = 4'd9;

   localparam int NORM_STEPS = 6;
   localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
   localparam logic signed [31:0] L2_BIAS = 32'sh2000_0000;
   localparam logic [PRODC_W-1:0] ROUND_HALF = PRODC_W'(64'd1 << 31);

   // Sequencer and stream state.
   logic [STATE_W-1:0]        state_ff, state_in;
   logic signed [SUM_W-1:0]   sel_sum_ff, sel_sum_in;
   logic signed [SUM_W-1:0]   all_sum_ff, all_sum_in;
   logic [COUNT_W-1:0]        sel_count_ff, sel_count_in;
   logic [COUNT_W-1:0]        all_count_ff, all_count_in;
   logic                      ovf_ff, ovf_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Per item working registers.
   logic [SCORE_W-1:0]        x_ff, x_in;
   logic [5:0]                lz_ff, lz_in;
   logic [2:0]                step_ff, step_in;
   logic                      sel_ff, sel_in;
   logic                      last_ff, last_in;
   logic                      bad_ff, bad_in;
   logic [ROM_W-1:0]          lo_ff, lo_in;
   logic [ROM_W-1:0]          hi_ff, hi_in;
   logic [RBITS-1:0]          rem_ff, rem_in;
   logic [5:0]                p_ff, p_in;
   logic [ROM_W+RBITS-1:0]    prodf_ff, prodf_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [PRODC_W-1:0]        prodc_ff, prodc_in;

   // Divider and result registers.
   logic [SUM_W-1:0]          num_ff, num_in;
   logic [COUNT_W:0]          drem_ff, drem_in;
   logic [COUNT_W-1:0]        divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0]      iter_ff, iter_in;
   logic                      res_neg_ff, res_neg_in;
   logic [1:0]                res_status_ff, res_status_in;
   logic [USED_W-1:0]         res_used_ff, res_used_in;
   logic signed [MEAN_W-1:0]  rsp_mean_ff, rsp_mean_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic [USED_W-1:0]         rsp_used_ff, rsp_used_in;

   // Combinational helpers.
   logic [6:0]                shift_amt;
   logic [31:0]               frac32;
   logic [TBL_BITS-1:0]       idx;
   logic [TBL_BITS:0]         idx_next;
   logic [ROM_W-1:0]          interp;
   logic signed [31:0]        l2;
   logic [PRODC_W-1:0]        prodc_round;
   logic [LG_W-1:0]           lg_mag;
   logic signed [LG_W-1:0]    lg;
   logic                      use_sel;
   logic [COUNT_W-1:0]        pick_count;
   logic signed [SUM_W-1:0]   pick_sum;
   logic [SUM_W-1:0]          pick_abs;
   logic [COUNT_W:0]          drem_shift;
   logic [SUM_W-1:0]          quot_signed;
   logic                      rsp_free;

   assign shift_amt   = 7'd32 >> step_ff;
   assign frac32      = x_ff[62:31];
   assign idx         = frac32[31 -: TBL_BITS];
   assign idx_next    = {1'b0, idx} + 1'b1;
   assign interp      = lo_ff + ROM_W'(prodf_ff >> RBITS);
   assign l2          = $signed(32'(p_ff) << 24) - L2_BIAS + $signed(32'(interp));
   assign prodc_round = prodc_ff + ROUND_HALF;
   assign lg_mag      = LG_W'(prodc_round >> 32);
   assign lg          = neg_ff ? -$signed(lg_mag) : $signed(lg_mag);
   assign use_sel     = (sel_count_ff != '0);
   assign pick_count  = use_sel ? sel_count_ff : all_count_ff;
   assign pick_sum    = use_sel ? sel_sum_ff : all_sum_ff;
   assign pick_abs    = pick_sum[SUM_W-1] ? SUM_W'(-pick_sum) : SUM_W'(pick_sum);
   assign drem_shift  = {drem_ff[COUNT_W-1:0], num_ff[SUM_W-1]};
   assign quot_signed = res_neg_ff ? -num_ff : num_ff;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   // Sequencer: one score at a time, then the mean on the last score.
   always_comb begin
      state_in      = state_ff;
      sel_sum_in    = sel_sum_ff;
      all_sum_in    = all_sum_ff;
      sel_count_in  = sel_count_ff;
      all_count_in  = all_count_ff;
      ovf_in        = ovf_ff;
      x_in          = x_ff;
      lz_in         = lz_ff;
      step_in       = step_ff;
      sel_in        = sel_ff;
      last_in       = last_ff;
      bad_in        = bad_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rem_in        = rem_ff;
      p_in          = p_ff;
      prodf_in      = prodf_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      prodc_in      = prodc_ff;
      num_in        = num_ff;
      drem_in       = drem_ff;
      divisor_in    = divisor_ff;
      iter_in       = iter_ff;
      res_neg_in    = res_neg_ff;
      res_status_in = res_status_ff;
      res_used_in   = res_used_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      q_pop         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               x_in     = {1'b0, q_rd_entry.score};
               sel_in   = q_rd_entry.sel;
               last_in  = q_rd_entry.last;
               bad_in   = q_rd_entry.bad;
               lz_in    = '0;
               step_in  = '0;
               state_in = S_NORM;
            end
         end
         // Binary search for the leading one, one shift width per cycle.
         S_NORM: begin
            if ((x_ff >> (7'd64 - shift_amt)) == '0) begin
               x_in  = x_ff << shift_amt;
               lz_in = lz_ff + 6'(shift_amt);
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 3'(NORM_STEPS - 1)) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            lo_in    = LOG_ROM[idx];
            hi_in    = LOG_ROM[idx_next];
            rem_in   = frac32[RBITS-1:0];
            p_in     = 6'd63 - lz_ff;
            state_in = S_MULF;
         end
         // Interpolation product between neighboring table entries.
         S_MULF: begin
            prodf_in = (ROM_W+RBITS)'(hi_ff - lo_ff) * (ROM_W+RBITS)'(rem_ff);
            state_in = S_L2;
         end
         S_L2: begin
            neg_in   = l2[31];
            mag_in   = l2[31] ? MAG_W'(-l2) : MAG_W'(l2);
            state_in = S_MULC;
         end
         // Scale log2 to log10.
         S_MULC: begin
            prodc_in = PRODC_W'(mag_ff) * PRODC_W'(LOG10_OF_2_Q32);
            state_in = S_ACC;
         end
         S_ACC: begin
            if (all_count_ff >= COUNT_W'(MAX_SCORES)) begin
               ovf_in = 1'b1;
            end else begin
               all_sum_in   = all_sum_ff + SUM_W'(lg);
               all_count_in = all_count_ff + 1'b1;
               if (sel_ff) begin
                  sel_sum_in   = sel_sum_ff + SUM_W'(lg);
                  sel_count_in = sel_count_ff + 1'b1;
               end
            end
            state_in = last_ff ? S_DIVSET : S_IDLE;
         end
         // Choose the sums for the mean and the status.
         S_DIVSET: begin
            divisor_in = pick_count;
            drem_in    = '0;
            iter_in    = '0;
            res_neg_in = pick_sum[SUM_W-1];
            if (bad_ff) begin
               res_status_in = ST_BAD;
               res_used_in   = '0;
            end else begin
               res_used_in   = USED_W'(pick_count);
               if (ovf_ff) begin
                  res_status_in = ST_OVF;
               end else begin
                  res_status_in = use_sel ? ST_OK : ST_FALLBACK;
               end
            end
            if (bad_ff || pick_count == '0) begin
               num_in   = '0;
               state_in = S_DONE;
            end else begin
               num_in   = pick_abs + SUM_W'(pick_count >> 1);
               state_in = S_DIV;
            end
         end
         // Restoring division, one quotient bit per cycle.
         S_DIV: begin
            if (drem_shift >= {1'b0, divisor_ff}) begin
               drem_in = drem_shift - {1'b0, divisor_ff};
               num_in  = {num_ff[SUM_W-2:0], 1'b1};
            end else begin
               drem_in = drem_shift;
               num_in  = {num_ff[SUM_W-2:0], 1'b0};
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == DIV_CNT_W'(SUM_W - 1)) begin
               state_in = S_DONE;
            end
         end
         // Hand the result over and start a fresh stream.
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_mean_in   = $signed(quot_signed[MEAN_W-1:0]);
               rsp_status_in = res_status_ff;
               rsp_used_in   = res_used_ff;
               sel_sum_in    = '0;
               all_sum_in    = '0;
               sel_count_in  = '0;
               all_count_in  = '0;
               ovf_in        = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and accumulators.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_sum_ff   <= '0;
         all_sum_ff   <= '0;
         sel_count_ff <= '0;
         all_count_ff <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_sum_ff   <= sel_sum_in;
         all_sum_ff   <= all_sum_in;
         sel_count_ff <= sel_count_in;
         all_count_ff <= all_count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      lz_ff         <= lz_in;
      step_ff       <= step_in;
      sel_ff        <= sel_in;
      last_ff       <= last_in;
      bad_ff        <= bad_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rem_ff        <= rem_in;
      p_ff          <= p_in;
      prodf_ff      <= prodf_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      prodc_ff      <= prodc_in;
      num_ff        <= num_in;
      drem_ff       <= drem_in;
      divisor_ff    <= divisor_in;
      iter_ff       <= iter_in;
      res_neg_ff    <= res_neg_in;
      res_status_ff <= res_status_in;
      res_used_ff   <= res_used_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean_log   = rsp_mean_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_used_count = rsp_used_ff;

   `OBML_ASSERT(a_sel_le_all, clock, reset, sel_count_ff <= all_count_ff, "selected count above total")
   `OBML_ASSERT(a_count_cap, clock, reset, all_count_ff <= COUNT_W'(MAX_SCORES), "count above limit")
   `OBML_ASSERT(a_bad_zero, clock, reset, (rsp_valid_ff && rsp_status_ff == ST_BAD) |-> (rsp_used_ff == '0 && rsp_mean_ff == '0), "bad band result not zero")

endmodule

`default_nettype wire

/* rtl/outer_band_mean_log10_score.sv */
// Top level of the outer band mean log10 score block.
//
// Scores enter on the req_ channel (valid/stall) as signed Q31.32 values with
// a last marker. Each score is clamped, classified against the band set in the
// two csr_ registers, and queued. A back end takes one queued score at a time,
// computes its log10 in Q5.24 and adds it to the running sums.
// The back end sequencer takes one score at a time through the six normalize
// steps, the table lookup and the two multiplies. The queue holds
// four scores, so req_stall rises only when the back end falls behind.
// A marked score yields one rsp_ transaction after the back end has taken it
// through that sequence and the bit-serial mean divider (skipped for a bad band).
// If rsp_stall holds off the result, the back end keeps it waiting and
// goes on with further scores up to the next marked one.
// Reset clears the thresholds to zero, the sums, counts and the queue; no
// clearing pass is needed. Write csr_ registers only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module outer_band_mean_log10_score import obml_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic signed [SCORE_W-1:0] req_score,
   input  wire logic                    req_last_score,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [MEAN_W-1:0]     rsp_mean_log,
   output logic [1:0]                   rsp_status,
   output logic [USED_W-1:0]            rsp_used_count,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [SCORE_W-1:0]      csr_data
);

   q_status_type q_status;
   q_entry_type  q_wr_entry;
   q_entry_type  q_rd_entry;
   logic         q_push;
   logic         q_pop;

   // Classification front end.
   obml_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_score      (req_score),
      .req_last_score (req_last_score),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_wr_entry     (q_wr_entry)
   );

   // Decoupling queue.
   obml_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (q_wr_entry),
      .pop      (q_pop),
      .rd_entry (q_rd_entry),
      .status   (q_status)
   );

   // Log, accumulate and divide back end.
   obml_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .q_rd_entry     (q_rd_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean_log   (rsp_mean_log),
      .rsp_status     (rsp_status),
      .rsp_used_count (rsp_used_count)
   );

endmodule

`default_nettype wire
